// ===== rtl/spb_pkg.sv =====
`timescale 1ns / 1ps

package spb_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_BITS    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

  localparam int STATUS_BITS = 2;

  localparam int IN_BITS     = 1 + HANDLE_BITS + KEY_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_BITS + 2 * HANDLE_BITS + 2 * KEY_BITS + 1 + COUNT_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } spb_ctrl_t;

endpackage

// ===== rtl/spb_cell.sv =====
`timescale 1ns / 1ps

module spb_cell (
  input  logic                            clk,
  input  spb_pkg::spb_ctrl_t              ctrl,
  input  logic                            occupied,
  input  logic                            left_gt,    // left neighbour stays put (tie high at head)
  input  logic [spb_pkg::KEY_BITS-1:0]    left_key,
  input  logic [spb_pkg::HANDLE_BITS-1:0] left_handle,
  input  logic [spb_pkg::KEY_BITS-1:0]    right_key,
  input  logic [spb_pkg::HANDLE_BITS-1:0] right_handle,
  output logic [spb_pkg::KEY_BITS-1:0]    key,
  output logic [spb_pkg::HANDLE_BITS-1:0] handle,
  output logic                            gt
);
  import spb_pkg::*;

  // Strictly greater keys stay ahead of the new entry
  assign gt = occupied && (key > ctrl.key);

  always_ff @(posedge clk) begin
    if (ctrl.ins && !gt) begin
      if (left_gt) begin
        key    <= ctrl.key;
        handle <= ctrl.handle;
      end else begin
        key    <= left_key;
        handle <= left_handle;
      end
    end else if (ctrl.rem) begin
      key    <= right_key;
      handle <= right_handle;
    end
  end

endmodule

// ===== rtl/sorted_priority_buffer.sv =====
`timescale 1ns / 1ps

// Sorted priority buffer.
// Input channel s_*: one item per request, opcode insert or remove-head.
// Output channel m_*: exactly one result item per request, carrying status,
// the removed entry (remove only), the head entry and the occupancy after it.
// Storage is a row of identical cells, head at cell 0. An insert compares
// the new key against every cell at once; cells with a greater key hold,
// the first other cell takes the new entry, the rest shift one place down.
// A remove shifts the whole row one place towards the head.
// Result: held in the output register, valid in the cycle after the request is taken.
// Throughput: one item per cycle while the receiver keeps m_tready high;
// set by the cell update plus the one output register.
// Stall: s_tready follows the output register, so a held result stops new
// requests from being taken until it leaves; nothing is lost.
// Reset: s_tready is held low, the count returns to zero and the output
// register empties; the cell contents are left as they are and are never
// read until written.
// Insert to a full buffer is dropped and reported full; remove from an
// empty buffer is reported empty.

module sorted_priority_buffer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // opcode[0], record_handle[16:1], iteration_key[32:17], zero fill
  input  logic [spb_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status[1:0], removed_handle[17:2], removed_key[33:18], head_valid[34],
  // head_handle[50:35], head_key[66:51], occupancy[71:67]
  output logic [spb_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import spb_pkg::*;

  // input unpack
  opcode_t                in_op;
  logic [HANDLE_BITS-1:0] in_handle;
  logic [KEY_BITS-1:0]    in_key;

  assign in_op     = opcode_t'(s_tdata[0]);
  assign in_handle = s_tdata[HANDLE_BITS:1];
  assign in_key    = s_tdata[HANDLE_BITS+KEY_BITS:HANDLE_BITS+1];

  logic                   accept;
  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   full;
  logic                   empty;
  spb_ctrl_t              ctrl;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == COUNT_BITS'(CAPACITY));
  assign empty    = (count == '0);

  assign ctrl.ins    = accept && (in_op == OP_INSERT) && !full;
  assign ctrl.rem    = accept && (in_op == OP_REMOVE) && !empty;
  assign ctrl.key    = in_key;
  assign ctrl.handle = in_handle;

  // row of cells
  logic [KEY_BITS-1:0]    cell_key    [CAPACITY];
  logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
  logic [CAPACITY-1:0]    cell_gt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   l_gt;
    logic [KEY_BITS-1:0]    l_key;
    logic [HANDLE_BITS-1:0] l_handle;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;

    if (i == 0) begin : g_head
      assign l_gt     = 1'b1;
      assign l_key    = '0;
      assign l_handle = '0;
    end else begin : g_body
      assign l_gt     = cell_gt[i-1];
      assign l_key    = cell_key[i-1];
      assign l_handle = cell_handle[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key    = cell_key[i];
      assign r_handle = cell_handle[i];
    end else begin : g_mid
      assign r_key    = cell_key[i+1];
      assign r_handle = cell_handle[i+1];
    end

    spb_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (COUNT_BITS'(i) < count),
      .left_gt      (l_gt),
      .left_key     (l_key),
      .left_handle  (l_handle),
      .right_key    (r_key),
      .right_handle (r_handle),
      .key          (cell_key[i]),
      .handle       (cell_handle[i]),
      .gt           (cell_gt[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) count_next = count + 1'b1;
    else if (ctrl.rem) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count_next;
  end

  // result assembly; head after the step comes from the row's next state
  status_t                res_status;
  logic [HANDLE_BITS-1:0] res_rem_handle;
  logic [KEY_BITS-1:0]    res_rem_key;
  logic [HANDLE_BITS-1:0] nxt_head_handle;
  logic [KEY_BITS-1:0]    nxt_head_key;
  logic                   res_head_valid;

  always_comb begin
    res_status      = ST_OK;
    res_rem_handle  = '0;
    res_rem_key     = '0;
    nxt_head_handle = cell_handle[0];
    nxt_head_key    = cell_key[0];
    if (in_op == OP_INSERT) begin
      if (full) res_status = ST_FULL;
      else if (!cell_gt[0]) begin
        nxt_head_handle = in_handle;
        nxt_head_key    = in_key;
      end
    end else begin
      if (empty) res_status = ST_EMPTY;
      else begin
        res_rem_handle  = cell_handle[0];
        res_rem_key     = cell_key[0];
        nxt_head_handle = cell_handle[1];
        nxt_head_key    = cell_key[1];
      end
    end
    res_head_valid = (count_next != '0);
    if (!res_head_valid) begin
      nxt_head_handle = '0;
      nxt_head_key    = '0;
    end
  end

  // output register
  status_t                out_status;
  logic [HANDLE_BITS-1:0] out_rem_handle;
  logic [KEY_BITS-1:0]    out_rem_key;
  logic                   out_head_valid;
  logic [HANDLE_BITS-1:0] out_head_handle;
  logic [KEY_BITS-1:0]    out_head_key;
  logic [COUNT_BITS-1:0]  out_occupancy;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (accept) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status      <= res_status;
      out_rem_handle  <= res_rem_handle;
      out_rem_key     <= res_rem_key;
      out_head_valid  <= res_head_valid;
      out_head_handle <= nxt_head_handle;
      out_head_key    <= nxt_head_key;
      out_occupancy   <= count_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_occupancy, out_head_key, out_head_handle,
                                 out_head_valid, out_rem_key, out_rem_handle,
                                 out_status});

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_full_drop : assert property (@(posedge clk) disable iff (rst)
    accept && (in_op == OP_INSERT) && full |=> m_tvalid && (out_status == ST_FULL)
      && (count == COUNT_BITS'(CAPACITY)))
    else $error("insert to full buffer not dropped");

  a_empty_remove : assert property (@(posedge clk) disable iff (rst)
    accept && (in_op == OP_REMOVE) && empty |=> m_tvalid && (out_status == ST_EMPTY)
      && (out_rem_key == '0) && (out_rem_handle == '0))
    else $error("remove from empty buffer misreported");

  a_head_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_head_valid == (out_occupancy != '0)) && (out_occupancy == count))
    else $error("head valid or occupancy inconsistent");
`endif

endmodule
